>>> rtl/gdd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types and constants for the draw-environment command decoder.
// ----------------------------------------------------------------------------
package gdd_pkg;

	// Opcodes in the top byte of a command word
	localparam logic [7:0] OPC_TPAGE   = 8'hE1;
	localparam logic [7:0] OPC_TWIN    = 8'hE2;
	localparam logic [7:0] OPC_AREA_TL = 8'hE3;
	localparam logic [7:0] OPC_AREA_BR = 8'hE4;
	localparam logic [7:0] OPC_OFFSET  = 8'hE5;

	// Texture window when both masks are zero (pass everything)
	localparam logic [31:0] TWIN_DEFAULT = 32'h0000_FFFF;

	// Last row of the displayed page, relative to its first row
	localparam logic [9:0] PAGE_LAST_ROW = 10'd239;

	// Default depth of the queue between decode and execute
	localparam int GDD_QUEUE_DEPTH = 4;

	// Classified command kind
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_TPAGE,
		CMD_TWIN,
		CMD_AREA_TL,
		CMD_AREA_BR,
		CMD_OFFSET
	} cmd_kind_t;

	// Decoded command as it travels through the queue
	typedef struct packed {
		cmd_kind_t   kind;
		logic [31:0] arg;
	} cmd_t;

endpackage : gdd_pkg
`default_nettype wire

>>> rtl/gpu_draw_environment_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gpu_draw_environment_decoder
// Decodes draw-environment commands E1..E5 and emits an environment
// snapshot after every command word.
//
// Input side is a queue write port: a word is taken on a clock edge with
// push high and full low. Result side is a queue read port: while empty is
// low the snapshot of the oldest word sits on the result ports, and it
// leaves on an edge with pop high. Every word, known opcode or not, yields
// exactly one snapshot.
// A pushed word is queued, then executed into the snapshot registers.
// Throughput is one word per cycle while the result side is draining.
// Decode is combinational. A queue of QUEUE_DEPTH decoded commands sits
// between decode and execute, so when the receiver stalls the block keeps
// accepting words until that queue fills, and then raises full.
// Reset clears the queue and snapshot slot and restores the environment
// defaults (pass-all texture window, page row zero). display_page_y is
// written with display_page_y_we by the user, only while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gpu_draw_environment_decoder
	import gdd_pkg::*;
#(
	parameter int QUEUE_DEPTH = GDD_QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          display_page_y_we,
	input  wire logic [8:0]    display_page_y,
	input  wire logic          push,
	output logic               full,
	input  wire logic [31:0]   command_word,
	output logic               empty,
	input  wire logic          pop,
	output logic [8:0]         texture_page,
	output logic [31:0]        texture_window,
	output logic [9:0]         clip_left,
	output logic [8:0]         clip_top,
	output logic signed [11:0] clip_width,
	output logic signed [9:0]  clip_height,
	output logic               clip_empty,
	output logic               clip_set,
	output logic signed [10:0] draw_offset_x,
	output logic signed [10:0] draw_offset_y
);

	logic q_wr;
	cmd_t q_wdata;
	logic q_full;
	logic q_rd;
	cmd_t q_rdata;
	logic q_empty;

	// Decode side
	gdd_front u_front (
		.push         (push),
		.full         (full),
		.command_word (command_word),
		.q_wr         (q_wr),
		.q_wdata      (q_wdata),
		.q_full       (q_full)
	);

	// Decoupling queue
	gdd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wdata   (q_wdata),
		.q_full  (q_full),
		.rd      (q_rd),
		.rdata   (q_rdata),
		.q_empty (q_empty)
	);

	// Execute side
	gdd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.display_page_y_we (display_page_y_we),
		.display_page_y    (display_page_y),
		.q_rdata           (q_rdata),
		.q_empty           (q_empty),
		.q_rd              (q_rd),
		.empty             (empty),
		.pop               (pop),
		.texture_page      (texture_page),
		.texture_window    (texture_window),
		.clip_left         (clip_left),
		.clip_top          (clip_top),
		.clip_width        (clip_width),
		.clip_height       (clip_height),
		.clip_empty        (clip_empty),
		.clip_set          (clip_set),
		.draw_offset_x     (draw_offset_x),
		.draw_offset_y     (draw_offset_y)
	);

endmodule : gpu_draw_environment_decoder
`default_nettype wire

>>> rtl/gdd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_front
// Accepts command words, classifies the opcode and prepares the payload
// (texture window packing) before handing the beat to the command queue.
// ----------------------------------------------------------------------------
module gdd_front
	import gdd_pkg::*;
(
	input  wire logic        push,
	output logic             full,
	input  wire logic [31:0] command_word,
	output logic             q_wr,
	output cmd_t             q_wdata,
	input  wire logic        q_full
);

	logic [4:0]  mask_x;
	logic [4:0]  mask_y;
	logic [4:0]  off_x;
	logic [4:0]  off_y;
	logic [31:0] window;

	// Back-pressure comes straight from the queue
	assign full = q_full;
	assign q_wr = push && !q_full;

	// Pack the texture window: inverted masks, then masked offsets, all times eight
	always_comb begin
		mask_x = command_word[4:0];
		mask_y = command_word[9:5];
		off_x  = command_word[14:10];
		off_y  = command_word[19:15];
		if (mask_x == 5'd0 && mask_y == 5'd0) begin
			window = TWIN_DEFAULT;
		end else begin
			window = {(off_y & mask_y), 3'b000,
				(off_x & mask_x), 3'b000,
				~{mask_y, 3'b000},
				~{mask_x, 3'b000}};
		end
	end

	// Classify the opcode
	always_comb begin
		q_wdata.arg = command_word;
		unique case (command_word[31:24])
			OPC_TPAGE:   q_wdata.kind = CMD_TPAGE;
			OPC_TWIN: begin
				q_wdata.kind = CMD_TWIN;
				q_wdata.arg  = window;
			end
			OPC_AREA_TL: q_wdata.kind = CMD_AREA_TL;
			OPC_AREA_BR: q_wdata.kind = CMD_AREA_BR;
			OPC_OFFSET:  q_wdata.kind = CMD_OFFSET;
			default:     q_wdata.kind = CMD_NONE;
		endcase
	end

endmodule : gdd_front
`default_nettype wire

>>> rtl/gdd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_queue
// Short first-in first-out queue of decoded commands between the decode
// and execute sides.
// ----------------------------------------------------------------------------
module gdd_queue
	import gdd_pkg::*;
#(
	parameter int DEPTH = GDD_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wdata,
	output logic      q_full,
	input  wire logic rd,
	output cmd_t      rdata,
	output logic      q_empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !q_full;
	assign do_rd   = rd && !q_empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store an incoming beat
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule : gdd_queue
`default_nettype wire

>>> rtl/gdd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdd_back
// Executes decoded commands against the environment state and holds the
// snapshot for the result side until it is taken.
// ----------------------------------------------------------------------------
module gdd_back
	import gdd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               display_page_y_we,
	input  wire logic [8:0]         display_page_y,
	input  wire cmd_t               q_rdata,
	input  wire logic               q_empty,
	output logic                    q_rd,
	output logic                    empty,
	input  wire logic               pop,
	output logic [8:0]              texture_page,
	output logic [31:0]             texture_window,
	output logic [9:0]              clip_left,
	output logic [8:0]              clip_top,
	output logic signed [11:0]      clip_width,
	output logic signed [9:0]       clip_height,
	output logic                    clip_empty,
	output logic                    clip_set,
	output logic signed [10:0]      draw_offset_x,
	output logic signed [10:0]      draw_offset_y
);

	logic        out_valid_q;
	logic [8:0]  page_y_q;
	logic [8:0]  page_bits_q;
	logic [31:0] window_q;
	logic [9:0]  area_left_q;
	logic [8:0]  area_top_q;
	logic [8:0]  rel_top_q;
	logic [11:0] width_q;
	logic [9:0]  height_q;
	logic        area_empty_q;
	logic        area_defined_q;
	logic [10:0] shift_x_q;
	logic [10:0] shift_y_q;

	logic        take;
	logic [8:0]  top;
	logic [9:0]  bot_limit;
	logic [9:0]  bot_clamped;
	logic [11:0] new_width;
	logic [10:0] new_height;
	logic        new_empty;

	// Execute when a command waits and the snapshot slot is free or leaving
	assign take  = !q_empty && (!out_valid_q || pop);
	assign q_rd  = take;
	assign empty = !out_valid_q;

	// Bottom-right corner: clamp to the page and size the area
	always_comb begin
		top         = (area_top_q > page_y_q) ? area_top_q : page_y_q;
		bot_limit   = {1'b0, page_y_q} + PAGE_LAST_ROW;
		bot_clamped = ({1'b0, q_rdata.arg[18:10]} > bot_limit) ?
			bot_limit : {1'b0, q_rdata.arg[18:10]};
		new_width   = {2'b00, q_rdata.arg[9:0]} - {2'b00, area_left_q} + 12'd1;
		new_height  = {1'b0, bot_clamped} - {2'b00, top} + 11'd1;
		new_empty   = new_width[11] || (new_width == 12'd0) ||
			new_height[10] || (new_height == 11'd0);
	end

	// Snapshot slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// Environment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_y_q       <= '0;
			page_bits_q    <= '0;
			window_q       <= TWIN_DEFAULT;
			area_left_q    <= '0;
			area_top_q     <= '0;
			rel_top_q      <= '0;
			width_q        <= '0;
			height_q       <= '0;
			area_empty_q   <= 1'b0;
			area_defined_q <= 1'b0;
			shift_x_q      <= '0;
			shift_y_q      <= '0;
		end else begin
			// Page register; the area top follows it until a top-left corner arrives
			if (display_page_y_we) begin
				page_y_q <= display_page_y;
				if (!area_defined_q) begin
					area_top_q <= display_page_y;
				end
			end
			if (take) begin
				unique case (q_rdata.kind)
					CMD_TPAGE: begin
						page_bits_q <= q_rdata.arg[8:0];
					end
					CMD_TWIN: begin
						window_q <= q_rdata.arg;
					end
					CMD_AREA_TL: begin
						area_left_q    <= q_rdata.arg[9:0];
						area_top_q     <= q_rdata.arg[18:10];
						area_defined_q <= 1'b1;
					end
					CMD_AREA_BR: begin
						width_q      <= new_width;
						height_q     <= new_height[9:0];
						rel_top_q    <= top - page_y_q;
						area_empty_q <= new_empty;
					end
					CMD_OFFSET: begin
						shift_x_q <= q_rdata.arg[10:0];
						shift_y_q <= q_rdata.arg[21:11];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// The state only moves when a snapshot is loaded, so it is the snapshot
	assign texture_page   = page_bits_q;
	assign texture_window = window_q;
	assign clip_left      = area_left_q;
	assign clip_top       = rel_top_q;
	assign clip_width     = $signed(width_q);
	assign clip_height    = $signed(height_q);
	assign clip_empty     = area_empty_q;
	assign clip_set       = area_defined_q;
	assign draw_offset_x  = $signed(shift_x_q);
	assign draw_offset_y  = $signed(shift_y_q);

endmodule : gdd_back
`default_nettype wire

>>> dv/tb_gpu_draw_environment_decoder.sv
// ----------------------------------------------------------------------------
// tb_gpu_draw_environment_decoder
// Self-checking bench for the draw-environment command decoder. Command
// words go in through the push/full port. Every accepted word is run through
// a local model of the environment state, which queues the snapshot that
// the block should emit. A checker compares each popped snapshot field by
// field against the oldest queued one. Directed words cover the field
// extremes and the corner cases. Random phases then run under several
// display page rows, with random idling on both sides in all but one.
// ----------------------------------------------------------------------------
module tb_gpu_draw_environment_decoder
	import gdd_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// One environment snapshot as seen on the result ports
	typedef struct packed {
		logic [8:0]  tex_page;
		logic [31:0] tex_window;
		logic [9:0]  left;
		logic [8:0]  top;
		logic [11:0] width;
		logic [9:0]  height;
		logic        is_empty;
		logic        is_set;
		logic [10:0] offset_x;
		logic [10:0] offset_y;
	} env_snapshot_t;

	localparam logic [7:0] ENV_OPCODES [5] = '{OPC_TPAGE, OPC_TWIN, OPC_AREA_TL,
		OPC_AREA_BR, OPC_OFFSET};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        display_page_y_we = 1'b0;
	logic [8:0]  display_page_y = '0;
	logic        push = 1'b0;
	logic [31:0] command_word = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [8:0]  texture_page;
	logic [31:0] texture_window;
	logic [9:0]  clip_left;
	logic [8:0]  clip_top;
	logic signed [11:0] clip_width;
	logic signed [9:0]  clip_height;
	logic        clip_empty;
	logic        clip_set;
	logic signed [10:0] draw_offset_x;
	logic signed [10:0] draw_offset_y;

	// Environment model state
	logic [8:0]  env_page_row;
	logic [8:0]  env_tex_page;
	logic [31:0] env_tex_window;
	logic [9:0]  env_area_left;
	logic [8:0]  env_area_top_row;
	logic [8:0]  env_rel_top;
	logic [11:0] env_width;
	logic [9:0]  env_height;
	logic        env_is_empty;
	logic        env_defined;
	logic [10:0] env_offset_x;
	logic [10:0] env_offset_y;

	env_snapshot_t pending_snapshots[$];
	int  mismatches = 0;
	int  snapshots_checked = 0;
	int  words_sent = 0;
	int  opcode_hits [6];
	int  page_writes = 0;
	bit  steady_flow = 1'b0;

	gpu_draw_environment_decoder u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.display_page_y_we (display_page_y_we),
		.display_page_y    (display_page_y),
		.push              (push),
		.full              (full),
		.command_word      (command_word),
		.empty             (empty),
		.pop               (pop),
		.texture_page      (texture_page),
		.texture_window    (texture_window),
		.clip_left         (clip_left),
		.clip_top          (clip_top),
		.clip_width        (clip_width),
		.clip_height       (clip_height),
		.clip_empty        (clip_empty),
		.clip_set          (clip_set),
		.draw_offset_x     (draw_offset_x),
		.draw_offset_y     (draw_offset_y)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// Apply one command word to the model and return the snapshot it yields
	function automatic env_snapshot_t apply_command(input logic [31:0] w);
		env_snapshot_t snap;
		logic [4:0] mask_x, mask_y, off_x, off_y;
		int right, bottom, page, top, width_i, height_i;
		case (w[31:24])
			OPC_TPAGE: begin
				env_tex_page = w[8:0];
				opcode_hits[1]++;
			end
			OPC_TWIN: begin
				mask_x = w[4:0];
				mask_y = w[9:5];
				off_x  = w[14:10];
				off_y  = w[19:15];
				if (mask_x == '0 && mask_y == '0)
					env_tex_window = TWIN_DEFAULT;
				else
					env_tex_window = {off_y & mask_y, 3'b000, off_x & mask_x, 3'b000,
						~{mask_y, 3'b000}, ~{mask_x, 3'b000}};
				opcode_hits[2]++;
			end
			OPC_AREA_TL: begin
				env_area_left    = w[9:0];
				env_area_top_row = w[18:10];
				env_defined      = 1'b1;
				opcode_hits[3]++;
			end
			OPC_AREA_BR: begin
				right  = int'(w[9:0]);
				bottom = int'(w[18:10]);
				page   = int'(env_page_row);
				top    = (int'(env_area_top_row) > page) ? int'(env_area_top_row) : page;
				// clamp the bottom row into the displayed page
				if (bottom > page + int'(PAGE_LAST_ROW))
					bottom = page + int'(PAGE_LAST_ROW);
				width_i  = right - int'(env_area_left) + 1;
				height_i = bottom - top + 1;
				env_width    = width_i[11:0];
				env_height   = height_i[9:0];
				env_rel_top  = 9'(top - page);
				env_is_empty = (width_i <= 0) || (height_i <= 0);
				opcode_hits[4]++;
			end
			OPC_OFFSET: begin
				env_offset_x = w[10:0];
				env_offset_y = w[21:11];
				opcode_hits[5]++;
			end
			default: begin
				opcode_hits[0]++;
			end
		endcase
		snap.tex_page   = env_tex_page;
		snap.tex_window = env_tex_window;
		snap.left       = env_area_left;
		snap.top        = env_rel_top;
		snap.width      = env_width;
		snap.height     = env_height;
		snap.is_empty   = env_is_empty;
		snap.is_set     = env_defined;
		snap.offset_x   = env_offset_x;
		snap.offset_y   = env_offset_y;
		return snap;
	endfunction

	// Enter at a falling edge; leave at the falling edge after the beat
	task automatic send_command(input logic [31:0] w);
		while (!steady_flow && $urandom_range(0, 99) < 27) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push         <= 1'b1;
		command_word <= w;
		@(posedge clk);
		while (full)
			@(posedge clk);
		pending_snapshots.push_back(apply_command(w));
		words_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every queued snapshot has been popped
	task automatic wait_for_snapshots();
		push <= 1'b0;
		while (pending_snapshots.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Only called with the block idle
	task automatic write_page_row(input logic [8:0] row);
		display_page_y_we <= 1'b1;
		display_page_y    <= row;
		@(negedge clk);
		display_page_y_we <= 1'b0;
		env_page_row = row;
		if (!env_defined)
			env_area_top_row = row;
		page_writes++;
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Random receiver stalls; none while the bench asks for steady flow
	always @(negedge clk) begin
		pop <= steady_flow || ($urandom_range(0, 99) >= 27);
	end

	// Check each popped snapshot against the oldest expectation
	always @(posedge clk) begin : check_snapshot
		env_snapshot_t want;
		if (arst_n && pop && !empty) begin
			if (pending_snapshots.size() == 0) begin
				$display("%0t: snapshot popped with none expected", $time);
				mismatches++;
			end else begin
				want = pending_snapshots.pop_front();
				report_field("texture_page", want.tex_page, texture_page);
				report_field("texture_window", want.tex_window, texture_window);
				report_field("clip_left", want.left, clip_left);
				report_field("clip_top", want.top, clip_top);
				report_field("clip_width", want.width, $unsigned(clip_width));
				report_field("clip_height", want.height, $unsigned(clip_height));
				report_field("clip_empty", want.is_empty, clip_empty);
				report_field("clip_set", want.is_set, clip_set);
				report_field("draw_offset_x", want.offset_x, $unsigned(draw_offset_x));
				report_field("draw_offset_y", want.offset_y, $unsigned(draw_offset_y));
				snapshots_checked++;
			end
		end
	end

	// Unknown opcodes leave the reset environment visible
	task automatic test_ignored_opcodes();
		send_command(32'h0000_0000);
		send_command(32'hFFFF_FFFF);
		send_command({8'hE0, 24'hFF_FFFF});
		send_command({8'hE6, 24'h00_0000});
		wait_for_snapshots();
	endtask

	// Page write before any top-left corner moves the area top row with it
	task automatic test_page_before_area();
		write_page_row(9'd300);
		send_command({OPC_AREA_BR, 5'h1F, 9'd511, 10'd1023});
		wait_for_snapshots();
		write_page_row(9'd0);
		send_command({OPC_AREA_BR, 5'h00, 9'd100, 10'd50});
		wait_for_snapshots();
	endtask

	task automatic test_texture_page();
		send_command({OPC_TPAGE, 15'h7FFF, 9'h1FF});
		send_command({OPC_TPAGE, 24'h00_0000});
		send_command({OPC_TPAGE, 15'h5555, 9'h0AA});
	endtask

	task automatic test_texture_window();
		send_command({OPC_TWIN, 4'hF, 5'h1F, 5'h1F, 5'h00, 5'h00});
		send_command({OPC_TWIN, 4'h0, 5'h1F, 5'h1F, 5'h1F, 5'h1F});
		send_command({OPC_TWIN, 4'h0, 5'h0A, 5'h15, 5'h00, 5'h1F});
		send_command({OPC_TWIN, 4'hA, 5'h15, 5'h0A, 5'h13, 5'h00});
	endtask

	// Full-size area, inverted area and zero-size areas
	task automatic test_drawing_area();
		send_command({OPC_AREA_TL, 5'h00, 9'd0, 10'd0});
		send_command({OPC_AREA_BR, 5'h00, 9'd511, 10'd1023});
		send_command({OPC_AREA_TL, 5'h1F, 9'd511, 10'd1023});
		send_command({OPC_AREA_BR, 5'h1F, 9'd0, 10'd0});
		send_command({OPC_AREA_TL, 5'h00, 9'd10, 10'd5});
		send_command({OPC_AREA_BR, 5'h00, 9'd100, 10'd4});
		send_command({OPC_AREA_BR, 5'h00, 9'd9, 10'd5});
	endtask

	task automatic test_draw_offset();
		send_command({OPC_OFFSET, 2'b00, 11'h400, 11'h3FF});
		send_command({OPC_OFFSET, 2'b11, 11'h3FF, 11'h400});
		send_command({OPC_OFFSET, 24'hFF_FFFF});
		send_command({OPC_OFFSET, 24'h00_0000});
		wait_for_snapshots();
	endtask

	// After a top-left corner a page write must leave the top row alone
	task automatic test_page_after_area();
		write_page_row(9'd511);
		send_command({OPC_AREA_BR, 5'h00, 9'd511, 10'd600});
		wait_for_snapshots();
	endtask

	// Mostly valid commands, corner pairs, and some raw noise
	task automatic test_random_mix(input int n_words, input logic [8:0] page_row,
		input bit no_gaps);
		logic [31:0] w;
		int pick;
		wait_for_snapshots();
		write_page_row(page_row);
		steady_flow = no_gaps;
		for (int i = 0; i < n_words; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				w = $urandom;
			end else if (pick < 40) begin
				// top-left then bottom-right, rows biased around the page
				send_command({OPC_AREA_TL, 5'($urandom),
					9'(int'(page_row) + $urandom_range(0, 300) - 40), 10'($urandom)});
				w = {OPC_AREA_BR, 5'($urandom),
					9'(int'(page_row) + $urandom_range(0, 320) - 20), 10'($urandom)};
			end else begin
				w = {ENV_OPCODES[$urandom_range(0, 4)], 24'($urandom)};
			end
			send_command(w);
			if (i == n_words / 2 && !no_gaps)
				wait_for_snapshots();
		end
		wait_for_snapshots();
		steady_flow = 1'b0;
	endtask

	initial begin
		env_page_row     = '0;
		env_tex_page     = '0;
		env_tex_window   = TWIN_DEFAULT;
		env_area_left    = '0;
		env_area_top_row = '0;
		env_rel_top      = '0;
		env_width        = '0;
		env_height       = '0;
		env_is_empty     = 1'b0;
		env_defined      = 1'b0;
		env_offset_x     = '0;
		env_offset_y     = '0;
		foreach (opcode_hits[k])
			opcode_hits[k] = 0;

		// Hold reset from time zero, release on a falling edge
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_ignored_opcodes();
		test_page_before_area();
		test_texture_page();
		test_texture_window();
		test_drawing_area();
		test_draw_offset();
		test_page_after_area();

		test_random_mix(200, 9'd0, 1'b0);
		test_random_mix(200, 9'd511, 1'b0);
		test_random_mix(180, 9'd271, 1'b1);
		test_random_mix(200, 9'($urandom), 1'b0);
		test_random_mix(180, 9'd240, 1'b0);
		test_random_mix(170, 9'd0, 1'b0);

		wait_for_snapshots();
		repeat (8) @(negedge clk);

		$display("Sent %0d words under %0d page-row settings; %0d snapshots checked.",
			words_sent, page_writes, snapshots_checked);
		$display("E1..E5 seen %0d/%0d/%0d/%0d/%0d times, other opcodes %0d times.",
			opcode_hits[1], opcode_hits[2], opcode_hits[3], opcode_hits[4],
			opcode_hits[5], opcode_hits[0]);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule : tb_gpu_draw_environment_decoder
